// ----- rtl/ttes_pkg.sv -----
// Shared types, character codes and helpers for the text tab-expand and strip block.
package ttes_pkg;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Most result bytes one request may produce; bytes beyond this are dropped.
    localparam int MAX_RESULTS = 64;

    localparam logic [4:0] TAB_WIDTH_MAX = 5'd16;

    typedef enum logic [1:0] {
        REG_TAB_WIDTH   = 2'd0,
        REG_STRIP_LINES = 2'd1,
        REG_STRIP_BLANK = 2'd2,
        REG_FORCE_NL    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_FLUSH,
        ST_TAIL,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [4:0] tab_width;
        logic       strip_lines;
        logic       strip_blank;
        logic       force_nl;
    } t_cfg;

    typedef struct packed {
        logic [3:0] phase;
        logic       at_line_start;
        logic       seen_content;
        logic       emitted_any;
        logic       last_was_nl;
    } t_strm;

    // What one request does: optional flush of the hold memory, then a run of
    // identical result bytes, or else a run of writes into the hold memory.
    typedef struct packed {
        logic       flush;
        logic       emit_valid;
        logic [7:0] data;
        logic [4:0] tail_cnt;
        logic [4:0] push_cnt;
        logic       hold_clear;
        logic       ovf;
        t_strm      strm_next;
    } t_plan;

    function automatic logic [4:0] eff_tab_width(input logic [4:0] w);
        return (w > TAB_WIDTH_MAX) ? TAB_WIDTH_MAX : w;
    endfunction

endpackage

// ----- rtl/ttes_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module ttes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ttes_plan.sv -----
// Request decoder: turns one request and the stream state into an action plan.
module ttes_plan #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic                                i_req,
    input  logic [7:0]                          i_data,
    input  ttes_pkg::t_cfg                      i_cfg,
    input  ttes_pkg::t_strm                     i_strm,
    input  logic [$clog2(HOLD_DEPTH+1)-1:0]     i_hold_cnt,
    output ttes_pkg::t_plan                     o_plan
);

    import ttes_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);

    logic [4:0]    tw;
    logic          is_tab;
    logic [4:0]    n_spaces;
    logic [7:0]    b_eff;
    logic [4:0]    cnt;
    logic          ws_line;
    logic          nl;
    logic          want_emit;
    logic          want_flush;
    logic          want_push;
    logic [6:0]    total;
    logic [CW-1:0] avail;
    logic [4:0]    phase_inc;
    t_plan         plan;

    always_comb begin
        tw        = eff_tab_width(i_cfg.tab_width);
        is_tab    = !i_req && (tw != 5'd0) && (i_data == CH_TAB);
        // The phase is already reduced below the tab width here.
        n_spaces  = tw - {1'b0, i_strm.phase};
        b_eff     = is_tab ? CH_SP : i_data;
        cnt       = is_tab ? n_spaces : 5'd1;
        ws_line   = (b_eff == CH_SP) || (b_eff == CH_TAB) || (b_eff == CH_CR);
        nl        = (b_eff == CH_LF) || (b_eff == CH_CR);
        total     = 7'(i_hold_cnt) + 7'(cnt);
        avail     = CW'(HOLD_DEPTH) - i_hold_cnt;
        phase_inc = {1'b0, i_strm.phase} + 5'd1;

        want_emit  = 1'b0;
        want_flush = 1'b0;
        want_push  = 1'b0;

        plan            = '0;
        plan.emit_valid = 1'b1;
        plan.data       = b_eff;
        plan.strm_next  = i_strm;

        if (i_req) begin
            plan.hold_clear = 1'b1;
            plan.tail_cnt   = 5'd1;
            if (!(i_cfg.force_nl && i_strm.emitted_any && !i_strm.last_was_nl)) begin
                plan.emit_valid = 1'b0;
                plan.data       = 8'h00;
            end else begin
                plan.data = CH_LF;
            end
            plan.strm_next               = '0;
            plan.strm_next.at_line_start = 1'b1;
        end else begin
            if (i_cfg.strip_lines) begin
                if (b_eff == CH_LF) begin
                    plan.hold_clear              = 1'b1;
                    want_emit                    = 1'b1;
                    plan.strm_next.at_line_start = 1'b1;
                end else if (ws_line) begin
                    want_push = !i_strm.at_line_start;
                end else begin
                    want_flush                   = 1'b1;
                    want_emit                    = 1'b1;
                    plan.strm_next.at_line_start = 1'b0;
                end
            end else if (i_cfg.strip_blank) begin
                if (nl) begin
                    want_push = i_strm.seen_content;
                end else begin
                    plan.strm_next.seen_content = 1'b1;
                    want_flush                  = 1'b1;
                    want_emit                   = 1'b1;
                end
            end else begin
                want_flush = 1'b1;
                want_emit  = 1'b1;
            end

            if (is_tab) begin
                plan.strm_next.phase = 4'd0;
            end else if (tw != 5'd0) begin
                plan.strm_next.phase = (phase_inc == tw) ? 4'd0 : phase_inc[3:0];
            end

            if (want_emit) begin
                plan.strm_next.emitted_any = 1'b1;
                plan.strm_next.last_was_nl = (b_eff == CH_LF);
                plan.tail_cnt              = cnt;
            end
            if (want_flush) begin
                plan.flush      = 1'b1;
                plan.hold_clear = 1'b1;
                if (total > 7'(MAX_RESULTS)) begin
                    plan.tail_cnt = 5'(7'(MAX_RESULTS) - 7'(i_hold_cnt));
                    plan.ovf      = 1'b1;
                end
            end
            if (want_push) begin
                if (7'(cnt) > 7'(avail)) begin
                    plan.push_cnt = 5'(avail);
                    plan.ovf      = 1'b1;
                end else begin
                    plan.push_cnt = cnt;
                end
            end
        end

        o_plan = plan;
    end

endmodule

// ----- rtl/text_tab_expand_and_strip.sv -----
// Top level of the streaming text cleaner: tab expansion and whitespace trimming.
//
// The block takes one request at a time. A request is accepted in ST_IDLE and
// decoded in the next cycle against the stream state; the block then sends each
// result byte and writes each held byte into the hold memory before it is ready
// again. When the tab width has been lowered to or below the current tab phase,
// a text request first subtracts the width from the phase until the phase is
// back under the new width. Held-back bytes are replayed from the hold memory one
// per cycle while the output is free, through its registered read port. A result
// waits in an output register until the downstream side takes it; while it is
// stalled the block holds the next result back. The hold memory needs no
// clearing pass after reset: only entries below the hold count are ever read.
// The user must write the configuration through the plain write port only while
// no request is in flight; the block itself does not enforce this.
module text_tab_expand_and_strip #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] req_type (1 = end of text)
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] hold_overflow, rest zero
    output logic [0:0]  m_axis_tuser,   // [0] out_valid
    output logic        m_axis_tlast,   // out_last
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [4:0]  i_cfg_wdata
);

    import ttes_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Control state.
    t_state        r_state, n_state;
    t_cfg          r_cfg, n_cfg;
    t_strm         r_strm, n_strm;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_hc, n_hc;
    logic          r_m_tvalid, n_m_tvalid;

    // Working registers of the request in flight.
    logic          r_req, n_req;
    logic [7:0]    r_data, n_data;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_flush_n, n_flush_n;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_val_flag, n_val_flag;
    logic [7:0]    r_val_data, n_val_data;

    // Output register payload.
    logic          r_m_valid_fld, n_m_valid_fld;
    logic [7:0]    r_m_data, n_m_data;
    logic          r_m_last, n_m_last;
    logic          r_m_ovf, n_m_ovf;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [4:0]    tw;
    logic          out_free;
    logic [CW-1:0] idx_inc;
    t_plan         plan;

    ttes_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ttes_plan #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_plan (
        .i_req      (r_req),
        .i_data     (r_data),
        .i_cfg      (r_cfg),
        .i_strm     (r_strm),
        .i_hold_cnt (r_hc),
        .o_plan     (plan)
    );

    assign tw       = eff_tab_width(r_cfg.tab_width);
    assign out_free = !r_m_tvalid || m_axis_tready;
    assign idx_inc  = r_idx + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_cfg         = r_cfg;
        n_strm        = r_strm;
        n_ovf         = r_ovf;
        n_hc          = r_hc;
        n_req         = r_req;
        n_data        = r_data;
        n_idx         = r_idx;
        n_flush_n     = r_flush_n;
        n_cnt         = r_cnt;
        n_val_flag    = r_val_flag;
        n_val_data    = r_val_data;
        n_m_tvalid    = r_m_tvalid && !m_axis_tready;
        n_m_valid_fld = r_m_valid_fld;
        n_m_data      = r_m_data;
        n_m_last      = r_m_last;
        n_m_ovf       = r_m_ovf;

        ram_we    = 1'b0;
        ram_waddr = r_hc[AW-1:0];
        ram_wdata = r_val_data;
        ram_re    = 1'b0;
        ram_raddr = '0;

        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_TAB_WIDTH:   n_cfg.tab_width   = i_cfg_wdata;
                REG_STRIP_LINES: n_cfg.strip_lines = i_cfg_wdata[0];
                REG_STRIP_BLANK: n_cfg.strip_blank = i_cfg_wdata[0];
                REG_FORCE_NL:    n_cfg.force_nl    = i_cfg_wdata[0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req   = s_axis_tuser[0];
                    n_data  = s_axis_tdata;
                    n_state = ST_NORM;
                end
            end

            ST_NORM: begin
                if (!r_req && (tw != 5'd0) && ({1'b0, r_strm.phase} >= tw)) begin
                    // Bring the tab phase back under a width that was lowered.
                    n_strm.phase = 4'({1'b0, r_strm.phase} - tw);
                end else begin
                    n_strm     = plan.strm_next;
                    n_ovf      = r_ovf | plan.ovf;
                    n_val_flag = plan.emit_valid;
                    n_val_data = plan.data;
                    n_flush_n  = r_hc;
                    n_idx      = '0;
                    if (plan.hold_clear) begin
                        n_hc = '0;
                    end
                    if (plan.flush && (r_hc != '0)) begin
                        ram_re  = 1'b1;
                        n_cnt   = plan.tail_cnt;
                        n_state = ST_FLUSH;
                    end else if (plan.tail_cnt != 5'd0) begin
                        n_cnt   = plan.tail_cnt;
                        n_state = ST_TAIL;
                    end else if (plan.push_cnt != 5'd0) begin
                        n_cnt   = plan.push_cnt;
                        n_state = ST_PUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_FLUSH: begin
                // Read data for r_idx is on the RAM output; it holds while stalled.
                if (out_free) begin
                    n_m_tvalid    = 1'b1;
                    n_m_valid_fld = 1'b1;
                    n_m_data      = ram_rdata;
                    n_m_last      = 1'b0;
                    n_m_ovf       = r_ovf;
                    n_idx         = idx_inc;
                    if (idx_inc == r_flush_n) begin
                        n_state = ST_TAIL;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end
            end

            ST_TAIL: begin
                if (out_free) begin
                    n_m_tvalid    = 1'b1;
                    n_m_valid_fld = r_val_flag;
                    n_m_data      = r_val_data;
                    n_m_last      = (r_cnt == 5'd1);
                    n_m_ovf       = r_ovf;
                    n_cnt         = r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_PUSH: begin
                ram_we = 1'b1;
                n_hc   = r_hc + 1'b1;
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg      <= '0;
            r_strm     <= '{phase: 4'd0, at_line_start: 1'b1, seen_content: 1'b0,
                            emitted_any: 1'b0, last_was_nl: 1'b0};
            r_ovf      <= 1'b0;
            r_hc       <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg      <= n_cfg;
            r_strm     <= n_strm;
            r_ovf      <= n_ovf;
            r_hc       <= n_hc;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_data        <= n_data;
        r_idx         <= n_idx;
        r_flush_n     <= n_flush_n;
        r_cnt         <= n_cnt;
        r_val_flag    <= n_val_flag;
        r_val_data    <= n_val_data;
        r_m_valid_fld <= n_m_valid_fld;
        r_m_data      <= n_m_data;
        r_m_last      <= n_m_last;
        r_m_ovf       <= n_m_ovf;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {7'd0, r_m_ovf, r_m_data};
    assign m_axis_tuser  = r_m_valid_fld;
    assign m_axis_tlast  = r_m_last;

endmodule

// ----- rtl/ttes_checker.sv -----
// Port-level assertions for the text cleaner, bound to its top level.
module ttes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic r_ovf_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[8]) begin
            r_ovf_seen <= 1'b1;
        end
    end

    // A result that is stalled stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed or was withdrawn");

    // Requests are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while the previous one is in flight");

    // An empty result only ends an end-of-text request and carries a zero byte.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
        else $error("empty result not last or with nonzero byte");

    // The overflow flag is sticky until reset.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_ovf_seen |-> m_axis_tdata[8])
        else $error("overflow flag dropped after being reported");

    // Padding bits of the result word stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
        else $error("result padding bits not zero");

endmodule

bind text_tab_expand_and_strip ttes_checker u_ttes_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for the streaming text cleaner (tab expansion and trimming).
`timescale 1ns / 1ps

module testbench;
    import ttes_pkg::*;

    localparam int      HOLD_DEPTH    = 63;
    localparam int      SETTLE_CYCLES = 100;
    localparam longint  TIMEOUT_NS    = 64'd1_000_000 * 12;
    localparam int      RAND_PHASES   = 10;

    // One request as the sender sees it: an end-of-text marker or a text byte.
    typedef struct packed {
        logic       eot;
        logic [7:0] data;
    } t_text_req;

    // One cleaned-text result with every field the block reports.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
        logic       hold_ovf;
    } t_clean_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] in_byte
    logic [0:0]  s_axis_tuser = 1'b0;      // [0] req_type (1 = end of text)
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] out_byte, [8] hold_overflow
    logic [0:0]  m_axis_tuser;             // [0] out_valid
    logic        m_axis_tlast;             // out_last
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = 2'd0;
    logic [4:0]  i_cfg_wdata = 5'd0;

    // Requests still to be driven, and cleaned-text results still to arrive.
    t_text_req     text_req_q[$];
    t_clean_result cleaned_text_q[$];

    int fail_cnt     = 0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    // Our own copy of the configuration; it changes only while the block is idle.
    logic [4:0] cfg_tab_width   = 5'd0;
    logic       cfg_strip_lines = 1'b0;
    logic       cfg_strip_blank = 1'b0;
    logic       cfg_force_nl    = 1'b0;

    // Stream state of the cleaner as the predictor tracks it.
    logic [3:0] tab_phase      = 4'd0;
    logic       at_line_start  = 1'b1;
    logic       seen_content   = 1'b0;
    logic       emitted_any    = 1'b0;
    logic       last_was_nl    = 1'b0;
    logic       ovf_seen       = 1'b0;
    logic [7:0] hold_mem [HOLD_DEPTH];
    int         hold_cnt       = 0;
    logic [7:0] burst_q[$];

    text_tab_expand_and_strip #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A byte leaves the cleaner. One request can send at most MAX_RESULTS bytes;
    // anything past that is lost and marks the sticky overflow flag.
    function automatic void put_byte(input logic [7:0] b);
        if (burst_q.size() < MAX_RESULTS) begin
            burst_q.insert(burst_q.size(), b);
            emitted_any = 1'b1;
            last_was_nl = (b == CH_LF);
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    function automatic void flush_hold();
        for (int i = 0; i < hold_cnt; i++) begin
            put_byte(hold_mem[i]);
        end
        hold_cnt = 0;
    endfunction

    // A held byte that finds the hold memory full is dropped.
    function automatic void hold_byte(input logic [7:0] b);
        if (hold_cnt < HOLD_DEPTH) begin
            hold_mem[hold_cnt] = b;
            hold_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    // Trimming stage, fed with bytes after tab expansion.
    function automatic void trim_byte(input logic [7:0] b);
        if (cfg_strip_lines) begin
            if (b == CH_LF) begin
                // Trailing blanks of the line are thrown away at the line break.
                hold_cnt = 0;
                put_byte(b);
                at_line_start = 1'b1;
            end else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
                if (!at_line_start) begin
                    hold_byte(b);
                end
            end else begin
                flush_hold();
                put_byte(b);
                at_line_start = 1'b0;
            end
        end else if (cfg_strip_blank) begin
            if (b == CH_LF || b == CH_CR) begin
                if (seen_content) begin
                    hold_byte(b);
                end
            end else begin
                seen_content = 1'b1;
                flush_hold();
                put_byte(b);
            end
        end else begin
            // With both trim modes off, anything still held goes out first.
            flush_hold();
            put_byte(b);
        end
    endfunction

    // Works out every result one accepted request causes and queues them.
    function automatic void predict_cleaned_text(input logic eot, input logic [7:0] b);
        int            tw;
        int            ph;
        int            n;
        t_clean_result res;
        tw = (cfg_tab_width > 5'd16) ? 16 : int'(cfg_tab_width);
        ph = int'(tab_phase);
        burst_q.delete();
        if (!eot) begin
            if (tw > 0 && b == CH_TAB) begin
                // The stop counts every expanded byte, not the column in the line;
                // a phase left from a wider setting is folded into the new width.
                n = tw - (ph % tw);
                repeat (n) trim_byte(CH_SP);
                tab_phase = 4'd0;
            end else begin
                trim_byte(b);
                if (tw > 0) begin
                    tab_phase = 4'(((ph % tw) + 1) % tw);
                end
            end
        end else begin
            hold_cnt = 0;
            if (cfg_force_nl && emitted_any && !last_was_nl) begin
                put_byte(CH_LF);
            end
            tab_phase     = 4'd0;
            at_line_start = 1'b1;
            seen_content  = 1'b0;
            emitted_any   = 1'b0;
            last_was_nl   = 1'b0;
        end
        if (eot && burst_q.size() == 0) begin
            // End of text with nothing to send still yields an empty result.
            res = '{out_valid: 1'b0, out_byte: 8'h00, out_last: 1'b1, hold_ovf: ovf_seen};
            cleaned_text_q.insert(cleaned_text_q.size(), res);
        end
        foreach (burst_q[k]) begin
            res.out_valid = 1'b1;
            res.out_byte  = burst_q[k];
            res.out_last  = (k == burst_q.size() - 1);
            res.hold_ovf  = ovf_seen;
            cleaned_text_q.insert(cleaned_text_q.size(), res);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver. A request stays on the bus until it is taken; after it is
    // taken the driver may pause for a short random burst.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        t_text_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (text_req_q.size() > 0) begin
                req = text_req_q.pop_front();
                s_axis_tvalid   <= 1'b1;
                s_axis_tdata    <= req.data;
                s_axis_tuser[0] <= req.eot;
                if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: random stall bursts, as often as sink_idle_pct asks.
    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(1, 6);
            end
        end
    end

    // Monitor. A request taken at this edge is predicted before any result taken at
    // the same edge is checked, so the order of the two never matters.
    always @(posedge i_clk) begin : stream_monitor
        t_clean_result got;
        t_clean_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_cleaned_text(s_axis_tuser[0], s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_valid = m_axis_tuser[0];
                got.out_byte  = m_axis_tdata[7:0];
                got.out_last  = m_axis_tlast;
                got.hold_ovf  = m_axis_tdata[8];
                if (cleaned_text_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h out_valid %0b",
                           got.out_byte, got.out_valid);
                    fail_cnt++;
                end else begin
                    want = cleaned_text_q.pop_front();
                    check_field("out_valid", want.out_valid, got.out_valid);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("out_last", want.out_last, got.out_last);
                    check_field("hold_overflow", want.hold_ovf, got.hold_ovf);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_text(input logic [7:0] b);
        text_req_q.insert(text_req_q.size(), t_text_req'{eot: 1'b0, data: b});
    endfunction

    // The data byte of an end-of-text request is ignored, so it carries noise.
    function automatic void push_end();
        text_req_q.insert(text_req_q.size(),
                          t_text_req'{eot: 1'b1, data: 8'($urandom_range(0, 255))});
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_text(s[i]);
        end
    endfunction

    function automatic logic [7:0] pick_word_byte();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Mostly text with plenty of blanks and line breaks, plus raw noise bytes.
    function automatic logic [7:0] pick_text_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return pick_word_byte();
        if (roll < 45) return CH_SP;
        if (roll < 55) return CH_TAB;
        if (roll < 63) return CH_CR;
        if (roll < 75) return CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // A long blank run fills the hold memory; what counts as blank depends on the
    // trim mode in force.
    function automatic void push_blank_run(input int count, input logic line_breaks);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            if (line_breaks) begin
                b = $urandom_range(0, 1) ? CH_CR : CH_LF;
            end else begin
                case ($urandom_range(0, 2))
                    0: b = CH_SP;
                    1: b = CH_TAB;
                    default: b = CH_CR;
                endcase
            end
            push_text(b);
        end
    endfunction

    function automatic void fill_random_phase(input int count, input logic long_runs);
        int made;
        int run_len;
        made = 0;
        while (made < count) begin
            if (long_runs && $urandom_range(0, 29) == 0) begin
                run_len = $urandom_range(58, 70);
                push_text(pick_word_byte());
                push_blank_run(run_len, cfg_strip_blank && !cfg_strip_lines);
                push_text($urandom_range(0, 1) ? CH_TAB : pick_word_byte());
                made += run_len + 2;
            end else if ($urandom_range(0, 24) == 0) begin
                push_end();
                made++;
            end else begin
                push_text(pick_text_byte());
                made++;
            end
        end
        // Half the phases leave the text open, so settings change in mid-text.
        if ($urandom_range(0, 1)) begin
            push_end();
        end
    endfunction

    function automatic logic [4:0] pick_tab_width();
        logic [4:0] widths [11];
        widths = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd7, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31};
        if ($urandom_range(0, 3) == 0) begin
            return 5'($urandom_range(0, 31));
        end
        return widths[$urandom_range(0, 10)];
    endfunction

    // Writes all four registers back to back, one per cycle, and mirrors them.
    task automatic load_settings(input logic [4:0] tw, input logic sl, input logic sb,
                                 input logic fn);
        t_reg_idx   order [4];
        logic [4:0] val;
        order = '{REG_TAB_WIDTH, REG_STRIP_LINES, REG_STRIP_BLANK, REG_FORCE_NL};
        foreach (order[i]) begin
            case (order[i])
                REG_TAB_WIDTH:   val = tw;
                REG_STRIP_LINES: val = {4'd0, sl};
                REG_STRIP_BLANK: val = {4'd0, sb};
                default:         val = {4'd0, fn};
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= order[i];
            i_cfg_wdata <= val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_tab_width   = tw;
        cfg_strip_lines = sl;
        cfg_strip_blank = sb;
        cfg_force_nl    = fn;
        // New requests are queued away from the clock edge.
        @(negedge i_clk);
    endtask

    // Waits until every request is taken and every result is in, then lets the
    // block finish any hold writes that produce no result.
    task automatic drain();
        while (text_req_q.size() != 0 || s_axis_tvalid || cleaned_text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic       sl;
        logic       sb;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: line trimming with tab stops of four. Leading blanks go, the
        // trailing blank and CR before the line break go, and the final newline
        // is appended after the lone 0xFF byte. The second end of text has no
        // output at all and so yields an empty result.
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        load_settings(5'd4, 1'b1, 1'b0, 1'b1);
        push_string("  a\tb ");
        push_text(CH_CR);
        push_text(CH_LF);
        push_text(8'hFF);
        push_end();
        push_end();
        drain();

        // Directed: a tab width above sixteen acts as sixteen, with blank-end
        // trimming. The text is left open with a CR/LF pair held back.
        load_settings(5'd20, 1'b0, 1'b1, 1'b1);
        push_text(CH_LF);
        push_text(CH_TAB);
        push_string("q");
        push_text(CH_CR);
        push_text(CH_LF);
        drain();

        // Directed: both trim modes off, so the held pair is flushed ahead of the
        // tab; the width drops to three while the tab phase sits at three.
        load_settings(5'd3, 1'b0, 1'b0, 1'b0);
        push_text(CH_TAB);
        push_text(8'h00);
        push_end();
        drain();

        // Random phases. The first two use the register extremes; long blank runs
        // that fill the hold memory come only later, since the overflow flag sticks.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            sl = 1'($urandom_range(0, 1));
            sb = 1'($urandom_range(0, 1));
            if (ph == 0) begin
                load_settings(5'd0, 1'b0, 1'b0, 1'b0);
            end else if (ph == 1) begin
                load_settings(5'd31, 1'b1, 1'b1, 1'b1);
            end else begin
                load_settings(pick_tab_width(), sl, sb, 1'($urandom_range(0, 1)));
            end
            src_idle_pct  = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
            sink_idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
            fill_random_phase(36, ph >= 5);
            drain();
        end

        // Overflow: a full hold of line breaks, one more that is dropped, and then
        // a tab of sixteen that flushes everything in one burst past the limit.
        load_settings(5'd16, 1'b0, 1'b1, 1'b0);
        push_end();
        push_text(pick_word_byte());
        push_blank_run(HOLD_DEPTH + 1, 1'b1);
        push_text(CH_TAB);
        push_end();
        drain();

        // Closing stretch with no idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_settings(pick_tab_width(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'b1);
        fill_random_phase(40, 1'b0);
        push_end();
        drain();

        if (fail_cnt == 0) begin
            $display("text_tab_expand_and_strip verification clean");
        end else begin
            $display("text_tab_expand_and_strip verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("text_tab_expand_and_strip verification failed");
        $finish;
    end

endmodule
